[rtl/apd_pkg.sv]
// ----------------------------------------------------------------------------
// apd_pkg: shared types and constants of the ADC power detector
// Fixed-point formats, calibration coefficients and register codes.
// ----------------------------------------------------------------------------
package apd_pkg;

  // sample and field widths
  localparam int ADC_BITS = 12;
  localparam int MV_W     = 12;
  localparam int PWR_W    = 16;
  localparam int Q_FRAC   = 16;

  // voltage in Q2.16, always below 3.3 V
  localparam int VQ_W     = 18;

  // accumulator wide enough for every Horner partial sum at 3.3 V
  localparam int ACC_W    = 40;

  // centi-dBm before saturation: acc * 100 rescaled by 2^-16
  localparam int SCALE_W  = 8;
  localparam int CENTI_W  = ACC_W + SCALE_W - Q_FRAC;

  // voltage scaling: vq = floor((code * 33 << (16 - ADC_BITS)) / 10)
  localparam int NUM_W       = 6 + Q_FRAC;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP10 = RECIP_W'(838861);
  localparam logic [NUM_W-1:0]   VOLT_MUL = NUM_W'(33);
  localparam int MV_PROD_W = ADC_BITS + 12;
  localparam logic [MV_PROD_W-1:0] MV_MUL = MV_PROD_W'(3300);

  // calibration polynomial, Q12.16, highest order first
  localparam int NUM_COEF     = 8;
  localparam int HORNER_STEPS = NUM_COEF - 1;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_Q16 [NUM_COEF] = '{
    ACC_W'(881459),    ACC_W'(-8362394),  ACC_W'(32656589), ACC_W'(-67567616),
    ACC_W'(79495168),  ACC_W'(-52684390), ACC_W'(19745997), ACC_W'(-6573261)
  };

  localparam logic signed [SCALE_W-1:0] CENTI_SCALE = 8'sd100;

  // configuration registers
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_POWER_THRESHOLD = 1'b0;
  localparam logic signed [PWR_W-1:0] THRESHOLD_RESET = -16'sd5000;

  // one sample travelling down the pipeline
  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic [VQ_W-1:0] vq;
    acc_t            acc;
  } apd_beat_t;

endpackage

[rtl/apd_scale.sv]
// ----------------------------------------------------------------------------
// apd_scale: input stage
// Masks the ADC code, derives millivolts and the Q2.16 voltage, seeds the
// accumulator with the leading coefficient.
// ----------------------------------------------------------------------------
module apd_scale
  import apd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [ADC_BITS-1:0] code_i,
  output logic                valid_o,
  input  logic                ready_i,
  output apd_beat_t           beat_o
);

  logic [MV_PROD_W-1:0]       mv_prod;
  logic [NUM_W-1:0]           num;
  logic [NUM_W+RECIP_W-1:0]   recip_prod;
  apd_beat_t                  beat_d, beat_q;
  logic                       valid_q;

  // millivolts, truncated
  assign mv_prod = MV_PROD_W'(code_i) * MV_MUL;

  // volts in Q2.16 through a reciprocal multiply by one tenth
  assign num        = (NUM_W'(code_i) * VOLT_MUL) << (Q_FRAC - ADC_BITS);
  assign recip_prod = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(RECIP10);

  always_comb begin
    beat_d.mv  = mv_prod[MV_PROD_W-1:ADC_BITS];
    beat_d.vq  = recip_prod[RECIP_SHIFT+VQ_W-1:RECIP_SHIFT];
    beat_d.acc = COEF_Q16[0];
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

[rtl/apd_horner_cell.sv]
// ----------------------------------------------------------------------------
// apd_horner_cell: one Horner step
// acc = round(acc * vq / 2^16) + coef, ties toward plus infinity, registered.
// ----------------------------------------------------------------------------
module apd_horner_cell
  import apd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  apd_beat_t beat_i,
  input  acc_t      coef_i,
  output logic      valid_o,
  input  logic      ready_i,
  output apd_beat_t beat_o
);

  logic signed [ACC_W+VQ_W:0] prod;
  logic signed [ACC_W+VQ_W:0] rnd;
  apd_beat_t                  beat_d, beat_q;
  logic                       valid_q;

  // multiply, round to nearest, add the next coefficient
  assign prod = $signed(beat_i.acc) * $signed({1'b0, beat_i.vq});
  assign rnd  = prod + $signed((ACC_W+VQ_W+1)'(1 << (Q_FRAC - 1)));

  always_comb begin
    beat_d     = beat_i;
    beat_d.acc = ACC_W'(rnd >>> Q_FRAC) + coef_i;
  end

  // stage register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

[rtl/apd_power_out.sv]
// ----------------------------------------------------------------------------
// apd_power_out: output stage
// Rescales to hundredths of dBm, saturates, compares against the threshold
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module apd_power_out
  import apd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  apd_beat_t               beat_i,
  input  logic signed [PWR_W-1:0] threshold_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [MV_W-1:0]         voltage_mv_o,
  output logic signed [PWR_W-1:0] power_centi_dbm_o,
  output logic                    above_threshold_o
);

  localparam logic signed [CENTI_W-1:0] SatMax = CENTI_W'(32767);
  localparam logic signed [CENTI_W-1:0] SatMin = CENTI_W'(-32768);

  logic signed [ACC_W+SCALE_W-1:0] scaled;
  logic signed [ACC_W+SCALE_W-1:0] rnd;
  logic signed [CENTI_W-1:0]       centi;
  logic signed [PWR_W-1:0]         sat_d;
  logic                            above_d;
  logic                            valid_q;
  logic [MV_W-1:0]                 mv_q;
  logic signed [PWR_W-1:0]         sat_q;
  logic                            above_q;

  // centi-dBm with rounding to nearest
  assign scaled = $signed(beat_i.acc) * CENTI_SCALE;
  assign rnd    = scaled + $signed((ACC_W+SCALE_W)'(1 << (Q_FRAC - 1)));
  assign centi  = CENTI_W'(rnd >>> Q_FRAC);

  // saturation and unsaturated threshold compare
  always_comb begin
    if (centi > SatMax) begin
      sat_d = PWR_W'(SatMax);
    end else if (centi < SatMin) begin
      sat_d = PWR_W'(SatMin);
    end else begin
      sat_d = PWR_W'(centi);
    end
    above_d = centi > CENTI_W'(threshold_i);
  end

  // output register
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mv_q    <= beat_i.mv;
      sat_q   <= sat_d;
      above_q <= above_d;
    end
  end

  assign valid_o           = valid_q;
  assign voltage_mv_o      = mv_q;
  assign power_centi_dbm_o = sat_q;
  assign above_threshold_o = above_q;

endmodule

[rtl/adc_power_polynomial_detector_core.sv]
// ----------------------------------------------------------------------------
// adc_power_polynomial_detector_core: RF power detector calibration
// Converts a detector ADC code to millivolts and to power in hundredths of
// dBm through a degree-7 calibration polynomial, with a threshold flag.
//
//   channel   signals                         payload
//   --------  ------------------------------  ------------------------------
//   sample    in_valid_i / in_ready_o         adc_sample_i
//   result    out_valid_o / out_ready_i       voltage_mv_o, power_centi_dbm_o,
//                                             above_threshold_o
//   config    APB psel .. pready              power_threshold at 0x0
//
// One sample per cycle while no stage stalls; the result comes out of nine register
// stages after its sample transfer: scaling stage, seven Horner cells (one
// multiplier each), output stage.
// Reset clears the stage valid bits and loads the threshold with -5000.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and samples keep entering while a result waits at the output, until all stages are full.
// ----------------------------------------------------------------------------
module adc_power_polynomial_detector_core
  import apd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // sample channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ADC_BITS-1:0]     adc_sample_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MV_W-1:0]         voltage_mv_o,
  output logic signed [PWR_W-1:0] power_centi_dbm_o,
  output logic                    above_threshold_o,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic signed [PWR_W-1:0] threshold_q;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    wr_en;

  apd_beat_t beat  [HORNER_STEPS+1];
  logic      valid [HORNER_STEPS+1];
  logic      ready [HORNER_STEPS+1];

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POWER_THRESHOLD: threshold_q <= pwdata[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POWER_THRESHOLD: prdata = 32'(threshold_q);
      default:             prdata = '0;
    endcase
  end

  // input scaling
  apd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .code_i  (adc_sample_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .beat_o  (beat[0])
  );

  // chain of Horner cells
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_cell
    apd_horner_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .beat_i  (beat[k]),
      .coef_i  (COEF_Q16[k+1]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .beat_o  (beat[k+1])
    );
  end

  // rescale, saturate, compare
  apd_power_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid[HORNER_STEPS]),
    .ready_o           (ready[HORNER_STEPS]),
    .beat_i            (beat[HORNER_STEPS]),
    .threshold_i       (threshold_q),
    .valid_o           (out_valid_o),
    .ready_i           (out_ready_i),
    .voltage_mv_o      (voltage_mv_o),
    .power_centi_dbm_o (power_centi_dbm_o),
    .above_threshold_o (above_threshold_o)
  );

endmodule

[test/tb_adc_power_polynomial_detector_core.sv]
// ----------------------------------------------------------------------------
// tb_adc_power_polynomial_detector_core: self-checking bench of the detector
// Feeds ADC codes over the sample channel under random idling on both sides
// and predicts millivolts, saturated centi-dBm and the threshold flag with a
// 64-bit Horner evaluation of the calibration polynomial. The threshold is
// reprogrammed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_adc_power_polynomial_detector_core;
  import apd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_SAMPLES  = 250;
  localparam int IDLE_PCT       = 28;

  // byte addresses of the register map, 4 bytes per register
  localparam logic [2:0] THRESHOLD_ADDR = {REG_POWER_THRESHOLD, 2'b00};
  localparam logic [2:0] UNUSED_ADDR    = 3'b100;

  // calibration polynomial in Q12.16, highest order first
  localparam longint CAL_Q16 [8] = '{
    881459, -8362394, 32656589, -67567616,
    79495168, -52684390, 19745997, -6573261
  };

  typedef struct packed {
    logic [MV_W-1:0]         mv;
    logic signed [PWR_W-1:0] pwr;
    logic                    above;
  } detection_t;

  typedef struct {
    logic [ADC_BITS-1:0] code;
    bit                  typed;
    detection_t          res;
  } sample_row_t;

  // directed samples; results typed in only for the trivial ends
  localparam int NUM_ROWS = 14;
  sample_row_t directed_rows [NUM_ROWS] = '{
    '{12'd0,    1'b1, '{12'd0,    -16'sd10030, 1'b0}},
    '{12'd4095, 1'b1, '{12'd3299, 16'sd32767,  1'b1}},
    '{12'd1,    1'b0, '0},
    '{12'd2,    1'b0, '0},
    '{12'd4094, 1'b0, '0},
    '{12'd2047, 1'b0, '0},
    '{12'd2048, 1'b0, '0},
    '{12'd2049, 1'b0, '0},
    '{12'd1024, 1'b0, '0},
    '{12'd3072, 1'b0, '0},
    '{12'hAAA,  1'b0, '0},
    '{12'h555,  1'b0, '0},
    '{12'd512,  1'b0, '0},
    '{12'd3584, 1'b0, '0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [ADC_BITS-1:0]     adc_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [MV_W-1:0]         voltage_mv_o;
  logic signed [PWR_W-1:0] power_centi_dbm_o;
  logic                    above_threshold_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  // predictor state and bookkeeping
  longint     threshold_centi;
  detection_t pending_detections [$];
  bit         calm;
  int         err_cnt;
  int         samples_sent;
  int         results_checked;
  int         reg_writes;
  int         quiet_cycles;

  adc_power_polynomial_detector_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .adc_sample_i      (adc_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .voltage_mv_o      (voltage_mv_o),
    .power_centi_dbm_o (power_centi_dbm_o),
    .above_threshold_o (above_threshold_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // q16 rescale, nearest with ties toward plus infinity
  function automatic longint round_q16(input longint p);
    return (p + 32768) >>> 16;
  endfunction

  // expected detection of one code under the current threshold
  function automatic detection_t predict_detection(input logic [ADC_BITS-1:0] code);
    longint     c;
    longint     vq;
    longint     acc;
    longint     centi;
    detection_t r;
    c   = longint'(code);
    vq  = ((c * 33 * 65536) / 10) >>> ADC_BITS;
    acc = CAL_Q16[0];
    for (int k = 1; k < 8; k++) begin
      acc = round_q16(acc * vq) + CAL_Q16[k];
    end
    centi   = round_q16(acc * 100);
    r.mv    = MV_W'((c * 3300) >>> ADC_BITS);
    if (centi > 32767) begin
      r.pwr = 16'sd32767;
    end else if (centi < -32768) begin
      r.pwr = -16'sd32768;
    end else begin
      r.pwr = PWR_W'(centi);
    end
    // flag compares against the unsaturated power
    r.above = (centi > threshold_centi);
    return r;
  endfunction

  // one sample transfer; valid stays up from the previous one unless idling
  task automatic send_sample(input logic [ADC_BITS-1:0] code, input detection_t exp);
    bit taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= code;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_detections.push_back(exp);
    samples_sent++;
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((addr >> 2) == 3'(REG_POWER_THRESHOLD)) begin
      threshold_centi = longint'(signed'(data[15:0]));
    end
    reg_writes++;
  endtask

  // drop valid and let the pipeline drain before touching the register
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random code with some weight on the ends of the range
  function automatic logic [ADC_BITS-1:0] pick_code();
    logic [ADC_BITS-1:0] ends [4] = '{12'd0, 12'd1, 12'd4094, 12'd4095};
    if ($urandom_range(7) == 0) begin
      return ends[$urandom_range(3)];
    end
    return ADC_BITS'($urandom_range(4095));
  endfunction

  // result side: random stalls, compare each transfer with the oldest expectation
  initial begin : result_check
    detection_t got;
    detection_t exp;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= (calm || $urandom_range(99) >= IDLE_PCT);
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{voltage_mv_o, power_centi_dbm_o, above_threshold_o};
        if (pending_detections.size() == 0) begin
          $error("result with no sample outstanding: mv=%0d power=%0d above=%0b",
                 got.mv, got.pwr, got.above);
          err_cnt++;
        end else begin
          exp = pending_detections.pop_front();
          if (got.mv !== exp.mv) begin
            $error("voltage_mv: expected %0d, got %0d", exp.mv, got.mv);
            err_cnt++;
          end
          if (got.pwr !== exp.pwr) begin
            $error("power_centi_dbm: expected %0d, got %0d", exp.pwr, got.pwr);
            err_cnt++;
          end
          if (got.above !== exp.above) begin
            $error("above_threshold: expected %0b, got %0b", exp.above, got.above);
            err_cnt++;
          end
          results_checked++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    detection_t  exp;
    logic [31:0] wdata;
    int          t;
    rst_ni          = 1'b0;
    in_valid_i      <= 1'b0;
    adc_sample_i    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    threshold_centi = -5000;
    calm            = 1'b0;
    err_cnt         = 0;
    samples_sent    = 0;
    results_checked = 0;
    reg_writes      = 0;
    quiet_cycles    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples under the reset threshold
    foreach (directed_rows[i]) begin
      exp = directed_rows[i].typed ? directed_rows[i].res
                                   : predict_detection(directed_rows[i].code);
      send_sample(directed_rows[i].code, exp);
    end

    // random phases, each with its own threshold
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      wdata = $urandom;
      case (ph)
        0: wdata[15:0] = 16'h8000;
        1: wdata[15:0] = 16'h7FFF;
        2: wdata[15:0] = 16'($urandom);
        default: begin
          // mostly inside the span the fitted power actually covers
          t = int'($urandom_range(44767)) - 12000;
          wdata[15:0] = t[15:0];
        end
      endcase
      write_reg(THRESHOLD_ADDR, wdata);
      // a write past the register map must leave the threshold alone
      if (ph == 2) begin
        write_reg(UNUSED_ADDR, ~wdata);
      end
      calm = (ph == 3);
      repeat (PHASE_SAMPLES) begin
        t = int'(pick_code());
        send_sample(ADC_BITS'(t), predict_detection(ADC_BITS'(t)));
      end
    end

    wait_drained();
    $display("covered %0d samples and %0d checked results over %0d register writes",
             samples_sent, results_checked, reg_writes);
    $display("thresholds included both 16-bit extremes and an ignored out-of-map write");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
